// ===== design/ctp_pkg.sv =====
// Shared types and constants for the conserved-to-primitive gas converter.
`timescale 1ns / 1ps
package ctp_pkg;

	localparam int HR_W  = 18;
	localparam int GC_W  = 31;
	localparam int DIM_W = 2;
	localparam int CFG_W = 31;
	localparam int IDX_W = 2;

	localparam logic [HR_W-1:0]  HR_RESET  = 18'd91750;
	localparam logic [GC_W-1:0]  GC_RESET  = 31'd18812211;
	localparam logic [DIM_W-1:0] DIM_RESET = 2'd2;

	typedef enum logic [IDX_W-1:0] {
		CFG_HEAT_RATIO   = 2'd0,
		CFG_GAS_CONSTANT = 2'd1,
		CFG_DIMENSION    = 2'd2
	} cfg_index_t;

	// per-item flags that ride alongside the arithmetic
	typedef struct packed {
		logic       bad;
		logic [2:0] vneg;
	} ctl_t;

endpackage

// ===== design/conserved_to_primitive_gas.sv =====
// Top level: pipelined ideal-gas conserved-to-primitive conversion.
//
// One node is taken on every clock where start is high; busy is always low.
// Each result shows on the output ports for one cycle with done high.
// The result path runs through two chained bit-per-stage dividers:
// kinetic energy (2*VALUE_WIDTH steps) and temperature
// (VALUE_WIDTH + 2*FRACTION_BITS steps); the velocity division runs
// beside them. Results cannot be held off, so they must be taken as
// they appear. Write configuration only while no node is in flight.
`timescale 1ns / 1ps
module conserved_to_primitive_gas #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            wr_en,
	input  logic [ctp_pkg::IDX_W-1:0]       wr_index,
	input  logic [ctp_pkg::CFG_W-1:0]       wr_data,
	input  logic signed [VALUE_WIDTH-1:0]   density,
	input  logic signed [VALUE_WIDTH-1:0]   momentum_x,
	input  logic signed [VALUE_WIDTH-1:0]   momentum_y,
	input  logic signed [VALUE_WIDTH-1:0]   momentum_z,
	input  logic signed [VALUE_WIDTH-1:0]   total_energy,
	output logic                            done,
	output logic signed [VALUE_WIDTH-1:0]   velocity_x,
	output logic signed [VALUE_WIDTH-1:0]   velocity_y,
	output logic signed [VALUE_WIDTH-1:0]   velocity_z,
	output logic signed [VALUE_WIDTH-1:0]   pressure,
	output logic signed [VALUE_WIDTH-1:0]   temperature,
	output logic                            bad_density,
	output logic                            saturated
);

	localparam int W    = VALUE_WIDTH;
	localparam int F    = FRACTION_BITS;
	localparam int HR_W = ctp_pkg::HR_W;
	localparam int GC_W = ctp_pkg::GC_W;
	localparam int GW   = ((HR_W > F) ? HR_W : F + 1) + 1;
	localparam int VW   = W + F;            // velocity quotient
	localparam int KW   = 2 * W;            // kinetic energy quotient
	localparam int TW   = W + 2 * F;        // temperature quotient
	localparam int RW   = W - 1 + GC_W;     // rho * R
	localparam int PW   = W + F + GW;       // pressure product
	localparam int QW   = W + 2 * F + GW + 1;
	localparam int DV   = VW + 1;
	localparam int DK   = KW + 1;
	localparam int DT   = TW + 1;
	localparam int TQ   = 6 + DK;
	localparam int TF   = TQ + DT + 1;
	localparam int CW   = $bits(ctp_pkg::ctl_t);

	localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

	// {overflow flag, clipped value}
	function automatic logic [W:0] sat_fn(input logic [QW-1:0] m, input logic neg);
		logic [QW-1:0] lim;
		logic [QW-1:0] neg_m;
		lim   = QW'(LIM);
		neg_m = -m;
		if (!neg) begin
			sat_fn = (m > lim) ? {1'b1, LIM} : {1'b0, m[W-1:0]};
		end else begin
			sat_fn = (m > lim + QW'(1)) ? {1'b1, ~LIM} : {1'b0, neg_m[W-1:0]};
		end
	endfunction

	// configuration
	logic [HR_W-1:0]             heat_ratio_q;
	logic [GC_W-1:0]             gas_constant_q;
	logic [ctp_pkg::DIM_W-1:0]   dimension_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_ratio_q   <= ctp_pkg::HR_RESET;
			gas_constant_q <= ctp_pkg::GC_RESET;
			dimension_q    <= ctp_pkg::DIM_RESET;
		end else if (wr_en) begin
			case (ctp_pkg::cfg_index_t'(wr_index))
				ctp_pkg::CFG_HEAT_RATIO:   heat_ratio_q   <= wr_data[HR_W-1:0];
				ctp_pkg::CFG_GAS_CONSTANT: gas_constant_q <= wr_data[GC_W-1:0];
				ctp_pkg::CFG_DIMENSION:    dimension_q    <= wr_data[ctp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic [TF:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[TF-1:1], start};
		end
	end

	// stage 1: magnitudes and flags
	logic [W-1:0]         mag_s1 [0:2];
	logic [W-2:0]         rho_s1;
	logic [W-1:0]         energy_s1;
	ctp_pkg::ctl_t        ctl_s1;
	logic                 use_y, use_z;

	assign use_y = dimension_q[1];
	assign use_z = &dimension_q;

	always_ff @(posedge clk) begin
		mag_s1[0]   <= momentum_x[W-1] ? -momentum_x : momentum_x;
		mag_s1[1]   <= !use_y ? '0 : (momentum_y[W-1] ? -momentum_y : momentum_y);
		mag_s1[2]   <= !use_z ? '0 : (momentum_z[W-1] ? -momentum_z : momentum_z);
		rho_s1      <= density[W-2:0];
		energy_s1   <= total_energy;
		ctl_s1.bad  <= density[W-1] || (density == '0);
		ctl_s1.vneg <= {momentum_z[W-1], momentum_y[W-1], momentum_x[W-1]};
	end

	// velocity dividers
	logic [VW-1:0] velq [0:2];
	for (genvar i = 0; i < 3; i++) begin : g_vel
		ctp_div #(.NUM_W(VW), .DEN_W(W-1)) u_div (
			.clk (clk),
			.num ({mag_s1[i], {F{1'b0}}}),
			.den (rho_s1),
			.quo (velq[i])
		);
	end

	// stages 2 and 3: squares, rho*R, sum of squares
	logic [2*W-1:0] sq_s2 [0:2];
	logic [RW-1:0]  rrp_s2;
	logic [W-2:0]   rho_s2, rho_s3;
	logic [2*W-1:0] sumsq_s3;
	logic [GC_W-1:0] gc_eff;

	assign gc_eff = (gas_constant_q == '0) ? GC_W'(1) : gas_constant_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= (2*W)'(mag_s1[i]) * (2*W)'(mag_s1[i]);
		end
		rrp_s2   <= RW'(rho_s1) * RW'(gc_eff);
		rho_s2   <= rho_s1;
		rho_s3   <= rho_s2;
		sumsq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	// kinetic energy = sum(m^2) / (2 rho)
	logic [KW-1:0] ke;
	ctp_div #(.NUM_W(KW), .DEN_W(W)) u_ke_div (
		.clk (clk),
		.num (sumsq_s3),
		.den ({rho_s3, 1'b0}),
		.quo (ke)
	);

	logic [W-1:0] energy_d;
	ctp_delay #(.WIDTH(W), .DEPTH(DK + 2)) u_energy_dly (
		.clk  (clk),
		.din  (energy_s1),
		.dout (energy_d)
	);

	// pressure: (gamma - 1) * (E - ke)
	logic signed [GW-1:0] g1;
	logic [GW-1:0]        gm;
	logic [2*W:0]         diff, dm;
	logic [VW-1:0]        dm_s;
	logic                 neg_s, neg_p;
	logic [PW-1:0]        prod_s;
	logic [PW:0]          rsum;
	logic [PW:0]          qp;
	logic [W-1:0]         pres_s;
	logic                 psat_s;

	assign g1   = GW'(heat_ratio_q) - (GW'(1) << F);
	assign gm   = g1[GW-1] ? -g1 : g1;
	assign diff = {{(W+1){energy_d[W-1]}}, energy_d} - {1'b0, ke};
	assign dm   = diff[2*W] ? -diff : diff;

	always_ff @(posedge clk) begin
		// a difference this large saturates for any nonzero gamma - 1
		dm_s   <= (|dm[2*W:VW]) ? '1 : dm[VW-1:0];
		neg_s  <= diff[2*W] != g1[GW-1];
		prod_s <= PW'(dm_s) * PW'(gm);
		neg_p  <= neg_s;
		{psat_s, pres_s} <= sat_fn(QW'(qp), neg_p);
	end

	assign rsum = {1'b0, prod_s} + ((PW+1)'(1) << (F - 1));
	assign qp   = rsum >> F;

	// temperature = p / (rho R)
	logic [RW-1:0] rrp_d;
	ctp_delay #(.WIDTH(RW), .DEPTH(TQ - 2)) u_rr_dly (
		.clk  (clk),
		.din  (rrp_s2),
		.dout (rrp_d)
	);

	logic [W-1:0]  pmag;
	logic [TW-1:0] tq;
	assign pmag = pres_s[W-1] ? -pres_s : pres_s;

	ctp_div #(.NUM_W(TW), .DEN_W(RW)) u_temp_div (
		.clk (clk),
		.num ({pmag, {(2*F){1'b0}}}),
		.den (rrp_d),
		.quo (tq)
	);

	// align side data with the temperature quotient
	logic [W-1:0]  pres_d;
	logic          psat_d;
	logic [VW-1:0] velq_d [0:2];
	ctp_pkg::ctl_t ctl_d;

	ctp_delay #(.WIDTH(W + 1), .DEPTH(DT)) u_pres_dly (
		.clk  (clk),
		.din  ({psat_s, pres_s}),
		.dout ({psat_d, pres_d})
	);

	for (genvar i = 0; i < 3; i++) begin : g_vel_dly
		ctp_delay #(.WIDTH(VW), .DEPTH(TQ + DT - 1 - DV)) u_dly (
			.clk  (clk),
			.din  (velq[i]),
			.dout (velq_d[i])
		);
	end

	ctp_delay #(.WIDTH(CW), .DEPTH(TQ + DT - 1)) u_ctl_dly (
		.clk  (clk),
		.din  (ctl_s1),
		.dout (ctl_d)
	);

	// final stage: clip and register results
	logic [W:0] vx_c, vy_c, vz_c, t_c;
	assign vx_c = sat_fn(QW'(velq_d[0]), ctl_d.vneg[0]);
	assign vy_c = sat_fn(QW'(velq_d[1]), ctl_d.vneg[1]);
	assign vz_c = sat_fn(QW'(velq_d[2]), ctl_d.vneg[2]);
	assign t_c  = sat_fn(QW'(tq), pres_d[W-1]);

	always_ff @(posedge clk) begin
		if (ctl_d.bad) begin
			velocity_x  <= '0;
			velocity_y  <= '0;
			velocity_z  <= '0;
			pressure    <= '0;
			temperature <= '0;
			bad_density <= 1'b1;
			saturated   <= 1'b0;
		end else begin
			velocity_x  <= vx_c[W-1:0];
			velocity_y  <= vy_c[W-1:0];
			velocity_z  <= vz_c[W-1:0];
			pressure    <= pres_d;
			temperature <= t_c[W-1:0];
			bad_density <= 1'b0;
			saturated   <= vx_c[W] | vy_c[W] | vz_c[W] | psat_d | t_c[W];
		end
	end

	assign done = vld_s[TF];

`ifndef SYNTHESIS
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_density |-> !saturated && temperature == '0 && pressure == '0)
		else $error("bad density transaction with nonzero results");

	a_zero_p: assert property (@(posedge clk) disable iff (!arst_n)
		done && pressure == '0 |-> temperature == '0)
		else $error("zero pressure gave nonzero temperature");

	a_neg_p: assert property (@(posedge clk) disable iff (!arst_n)
		done && pressure[W-1] |-> temperature[W-1] || temperature == '0)
		else $error("negative pressure gave positive temperature");
`endif

endmodule

// ===== design/ctp_delay.sv =====
// Fixed-depth delay line for data that bypasses the long arithmetic stages.
`timescale 1ns / 1ps
module ctp_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [0:DEPTH-1];

	always_ff @(posedge clk) begin
		tap_s[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

// ===== design/ctp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round half up on the remainder.
`timescale 1ns / 1ps
module ctp_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] qn_s  [0:NUM_W];
	logic [DEN_W-1:0] rem_s [0:NUM_W];
	logic [DEN_W-1:0] den_s [0:NUM_W];
	logic [DEN_W-1:0] half;

	assign qn_s[0]  = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k], qn_s[k][NUM_W-1]};
		assign ge    = trial >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, den_s[k]}) : trial[DEN_W-1:0];
			qn_s[k+1]  <= {qn_s[k][NUM_W-2:0], ge};
			den_s[k+1] <= den_s[k];
		end
	end

	// ceil(den/2)
	assign half = den_s[NUM_W] - (den_s[NUM_W] >> 1);

	always_ff @(posedge clk) begin
		quo <= qn_s[NUM_W] + NUM_W'(rem_s[NUM_W] >= half);
	end

endmodule
